// ===== rtl/swarq_pkg.sv =====
// Shared types and constants for the sliding-window ARQ sender.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps
`default_nettype none

package swarq_pkg;

    localparam int SEQ_W      = 16;
    localparam int TIME_W     = 32;
    localparam int CMD_W      = 2;
    localparam int KIND_W     = 2;
    localparam int TX_SLOT_W  = 4;
    localparam int TMO_W      = 8;
    localparam int DUP_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // At most this many transmissions come out of one command.
    localparam int MAX_RESULTS = 5;
    localparam int RES_IDX_W   = 3;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_SEND    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ACK     = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NEW    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TMO    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DUP    = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ARQ_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RTX_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PKTS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DUP_THRESH  = 2'd3;

    // Register reset values
    localparam logic             RST_ARQ_MODE    = 1'b0;
    localparam logic [TMO_W-1:0] RST_RTX_TIMEOUT = 8'd2;
    localparam logic [SEQ_W-1:0] RST_TOTAL_PKTS  = 16'd20;
    localparam logic [DUP_W-1:0] RST_DUP_THRESH  = 3'd3;

    localparam logic [DUP_W-1:0] DUP_SAT = 3'd7;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // latch input transaction, clear result buffer
        logic do_send;   // one new transmission
        logic do_tmo;    // check one slot of the timeout walk
        logic do_ack;    // ack bookkeeping
        logic do_adv;    // move base over one acked slot
        logic emit_pop;  // current result taken
    } dp_ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic send_more;
        logic walk_more;
        logic ack_in_range;
        logic adv_more;
        logic emit_last;
    } dp_status_t;

endpackage : swarq_pkg

`default_nettype wire

// ===== rtl/swarq_in_if.sv =====
// Input command channel (valid/ready plus cmd, ack_number, now_time) and output result channel.
// Depends on swarq_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface swarq_in_if;
    logic                          valid;
    logic                          ready;
    logic [swarq_pkg::CMD_W-1:0]   cmd;
    logic [swarq_pkg::SEQ_W-1:0]   ack_number;
    logic [swarq_pkg::TIME_W-1:0]  now_time;

    modport source (output valid, output cmd, output ack_number, output now_time,
                    input ready);
    modport sink   (input valid, input cmd, input ack_number, input now_time,
                    output ready);
endinterface : swarq_in_if

interface swarq_out_if;
    logic                             valid;
    logic                             ready;
    logic [swarq_pkg::KIND_W-1:0]     kind;
    logic [swarq_pkg::SEQ_W-1:0]      tx_seq;
    logic [swarq_pkg::TX_SLOT_W-1:0]  tx_slot;
    logic [swarq_pkg::SEQ_W-1:0]      base_now;
    logic [swarq_pkg::SEQ_W-1:0]      next_now;
    logic                             finished;
    logic                             last;

    modport source (output valid, output kind, output tx_seq, output tx_slot,
                    output base_now, output next_now, output finished, output last,
                    input ready);
    modport sink   (input valid, input kind, input tx_seq, input tx_slot,
                    input base_now, input next_now, input finished, input last,
                    output ready);
endinterface : swarq_out_if

`default_nettype wire

// ===== rtl/swarq_ctrl.sv =====
// Sequencing state machine of the ARQ sender.
// Depends on swarq_pkg (dp_ctl_t, dp_status_t, command codes).
`timescale 1ns / 1ps
`default_nettype none

module swarq_ctrl
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    input  wire  [swarq_pkg::CMD_W-1:0]  in_cmd,
    output logic                         in_ready,
    output logic                         out_valid,
    input  wire                          out_ready,
    output swarq_pkg::dp_ctl_t           ctl,
    input  swarq_pkg::dp_status_t        st
);
    import swarq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEND,
        S_TMO,
        S_ACK,
        S_ADV,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_fire;
    logic   out_fire;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_EMIT);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;

    always_comb
    begin
        ctl          = '0;
        ctl.capture  = in_fire;
        ctl.do_send  = (state_reg == S_SEND) && st.send_more;
        ctl.do_tmo   = (state_reg == S_TMO) && st.walk_more;
        ctl.do_ack   = (state_reg == S_ACK);
        ctl.do_adv   = (state_reg == S_ADV) && st.adv_more;
        ctl.emit_pop = out_fire;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_cmd)
                        CMD_SEND:    state_next = S_SEND;
                        CMD_TIMEOUT: state_next = S_TMO;
                        CMD_ACK:     state_next = S_ACK;
                        default:     state_next = S_EMIT;
                    endcase
                end
            end
            S_SEND:
            begin
                if (!st.send_more)
                    state_next = S_EMIT;
            end
            S_TMO:
            begin
                if (!st.walk_more)
                    state_next = S_EMIT;
            end
            S_ACK:
            begin
                state_next = st.ack_in_range ? S_ADV : S_EMIT;
            end
            S_ADV:
            begin
                if (!st.adv_more)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_fire && st.emit_last)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule : swarq_ctrl

`default_nettype wire

// ===== rtl/swarq_datapath.sv =====
// Window state, configuration registers and result buffer of the ARQ sender.
// Depends on swarq_pkg; driven by swarq_ctrl through dp_ctl_t.
`timescale 1ns / 1ps
`default_nettype none

module swarq_datapath
#(
    parameter int WINDOW = 4
)
(
    input  wire                                clk,
    input  wire                                rst_n,
    input  swarq_pkg::dp_ctl_t                 ctl,
    output swarq_pkg::dp_status_t              st,
    input  wire  [swarq_pkg::SEQ_W-1:0]        in_ack_number,
    input  wire  [swarq_pkg::TIME_W-1:0]       in_now_time,
    input  wire                                cfg_we,
    input  wire  [swarq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [swarq_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic [swarq_pkg::KIND_W-1:0]       out_kind,
    output logic [swarq_pkg::SEQ_W-1:0]        out_tx_seq,
    output logic [swarq_pkg::TX_SLOT_W-1:0]    out_tx_slot,
    output logic [swarq_pkg::SEQ_W-1:0]        out_base_now,
    output logic [swarq_pkg::SEQ_W-1:0]        out_next_now,
    output logic                               out_finished,
    output logic                               out_last
);
    import swarq_pkg::*;

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W  = SLOT_W + 2;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
    localparam logic [SUM_W-1:0]  WIN_SUM   = SUM_W'(WINDOW);
    localparam logic [SEQ_W:0]    WIN_SEQ   = (SEQ_W + 1)'(WINDOW);

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        slot_inc = (s == SLOT_LAST) ? '0 : s + 1'b1;
    endfunction

    // configuration
    logic             arq_mode_reg,  arq_mode_next;
    logic [TMO_W-1:0] rtx_tmo_reg,   rtx_tmo_next;
    logic [SEQ_W-1:0] total_reg,     total_next;
    logic [DUP_W-1:0] dup_thr_reg,   dup_thr_next;

    // window control state
    logic [SEQ_W-1:0]  base_reg,       base_next;
    logic [SEQ_W-1:0]  head_seq_reg,   head_seq_next;
    logic [SLOT_W-1:0] base_slot_reg,  base_slot_next;
    logic [SLOT_W-1:0] next_slot_reg,  next_slot_next;
    logic [WINDOW-1:0] acked_reg,      acked_next;
    logic [SEQ_W-1:0]  last_ack_reg,   last_ack_next;
    logic              last_ack_v_reg, last_ack_v_next;
    logic [DUP_W-1:0]  dup_cnt_reg,    dup_cnt_next;
    logic [RES_IDX_W-1:0] res_cnt_reg, res_cnt_next;
    logic [RES_IDX_W-1:0] emit_idx_reg, emit_idx_next;

    // payload state
    logic [TIME_W-1:0] sent_time_reg [WINDOW];
    logic [TIME_W-1:0] sent_time_next [WINDOW];
    logic [SEQ_W-1:0]  ack_reg,       ack_next;
    logic [TIME_W-1:0] now_reg,       now_next;
    logic [SEQ_W-1:0]  walk_seq_reg,  walk_seq_next;
    logic [SLOT_W-1:0] walk_slot_reg, walk_slot_next;
    logic [KIND_W-1:0] res_kind_reg [MAX_RESULTS];
    logic [KIND_W-1:0] res_kind_next [MAX_RESULTS];
    logic [SEQ_W-1:0]  res_seq_reg  [MAX_RESULTS];
    logic [SEQ_W-1:0]  res_seq_next [MAX_RESULTS];
    logic [SLOT_W-1:0] res_slot_reg [MAX_RESULTS];
    logic [SLOT_W-1:0] res_slot_next [MAX_RESULTS];

    // decode
    logic              room;
    logic [SEQ_W-1:0]  ack_off;
    logic [SUM_W-1:0]  ack_sum;
    logic [SLOT_W-1:0] ack_slot;
    logic [SLOT_W-1:0] tgt_slot;
    logic [SEQ_W:0]    tgt_seq;
    logic [DUP_W-1:0]  dup_inc;
    logic [TIME_W-1:0] walk_age;
    logic              walk_due;

    assign room = (res_cnt_reg < RES_IDX_W'(MAX_RESULTS));

    assign st.send_more = room
                       && ({1'b0, head_seq_reg} < ({1'b0, base_reg} + WIN_SEQ))
                       && (head_seq_reg < total_reg);
    assign st.walk_more = room && (walk_seq_reg < head_seq_reg);
    assign st.ack_in_range = (ack_reg >= base_reg) && (ack_reg < head_seq_reg);
    assign st.adv_more = (base_reg < head_seq_reg) && (base_reg < total_reg)
                      && acked_reg[base_slot_reg];
    assign st.emit_last = (res_cnt_reg == '0) || (emit_idx_reg == res_cnt_reg - 1'b1);

    // ack sits less than WINDOW above base, so one compare-subtract wraps the slot
    assign ack_off  = ack_reg - base_reg;
    assign ack_sum  = SUM_W'(base_slot_reg) + SUM_W'(ack_off[SLOT_W-1:0]);
    assign ack_slot = (ack_sum >= WIN_SUM) ? SLOT_W'(ack_sum - WIN_SUM) : SLOT_W'(ack_sum);
    assign tgt_slot = arq_mode_reg ? slot_inc(ack_slot) : ack_slot;
    assign tgt_seq  = {1'b0, ack_reg} + (SEQ_W + 1)'(arq_mode_reg);
    assign dup_inc  = dup_cnt_reg + 1'b1;

    assign walk_age = now_reg - sent_time_reg[walk_slot_reg];
    assign walk_due = !acked_reg[walk_slot_reg]
                   && (arq_mode_reg || (walk_age >= TIME_W'(rtx_tmo_reg)));

    always_comb
    begin
        arq_mode_next   = arq_mode_reg;
        rtx_tmo_next    = rtx_tmo_reg;
        total_next      = total_reg;
        dup_thr_next    = dup_thr_reg;
        base_next       = base_reg;
        head_seq_next   = head_seq_reg;
        base_slot_next  = base_slot_reg;
        next_slot_next  = next_slot_reg;
        acked_next      = acked_reg;
        last_ack_next   = last_ack_reg;
        last_ack_v_next = last_ack_v_reg;
        dup_cnt_next    = dup_cnt_reg;
        res_cnt_next    = res_cnt_reg;
        emit_idx_next   = emit_idx_reg;
        sent_time_next  = sent_time_reg;
        ack_next        = ack_reg;
        now_next        = now_reg;
        walk_seq_next   = walk_seq_reg;
        walk_slot_next  = walk_slot_reg;
        res_kind_next   = res_kind_reg;
        res_seq_next    = res_seq_reg;
        res_slot_next   = res_slot_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ARQ_MODE:    arq_mode_next = cfg_data[0];
                CFG_RTX_TIMEOUT: rtx_tmo_next  = cfg_data[TMO_W-1:0];
                CFG_TOTAL_PKTS:  total_next    = cfg_data[SEQ_W-1:0];
                CFG_DUP_THRESH:  dup_thr_next  = cfg_data[DUP_W-1:0];
                default:         ;
            endcase
        end

        if (ctl.capture)
        begin
            ack_next       = in_ack_number;
            now_next       = in_now_time;
            walk_seq_next  = base_reg;
            walk_slot_next = base_slot_reg;
            res_cnt_next   = '0;
            emit_idx_next  = '0;
        end

        if (ctl.do_send)
        begin
            acked_next[next_slot_reg]     = 1'b0;
            sent_time_next[next_slot_reg] = now_reg;
            res_kind_next[res_cnt_reg]    = KIND_NEW;
            res_seq_next[res_cnt_reg]     = head_seq_reg;
            res_slot_next[res_cnt_reg]    = next_slot_reg;
            res_cnt_next                  = res_cnt_reg + 1'b1;
            head_seq_next                 = head_seq_reg + 1'b1;
            next_slot_next                = slot_inc(next_slot_reg);
        end

        if (ctl.do_tmo)
        begin
            if (walk_due)
            begin
                sent_time_next[walk_slot_reg] = now_reg;
                res_kind_next[res_cnt_reg]    = KIND_TMO;
                res_seq_next[res_cnt_reg]     = walk_seq_reg;
                res_slot_next[res_cnt_reg]    = walk_slot_reg;
                res_cnt_next                  = res_cnt_reg + 1'b1;
            end
            walk_seq_next  = walk_seq_reg + 1'b1;
            walk_slot_next = slot_inc(walk_slot_reg);
        end

        if (ctl.do_ack && st.ack_in_range)
        begin
            if (last_ack_v_reg && (ack_reg == last_ack_reg))
            begin
                if (dup_cnt_reg < DUP_SAT)
                begin
                    dup_cnt_next = dup_inc;
                    // fast retransmit fires once, on reaching the threshold
                    if ((dup_inc == dup_thr_reg) && (tgt_seq < {1'b0, head_seq_reg}))
                    begin
                        sent_time_next[tgt_slot] = now_reg;
                        res_kind_next[0]         = KIND_DUP;
                        res_seq_next[0]          = tgt_seq[SEQ_W-1:0];
                        res_slot_next[0]         = tgt_slot;
                        res_cnt_next             = RES_IDX_W'(1);
                    end
                end
            end
            else
            begin
                last_ack_next   = ack_reg;
                last_ack_v_next = 1'b1;
                dup_cnt_next    = arq_mode_reg ? DUP_W'(0) : DUP_W'(1);
            end
            acked_next[ack_slot] = 1'b1;
        end

        if (ctl.do_adv)
        begin
            base_next      = base_reg + 1'b1;
            base_slot_next = slot_inc(base_slot_reg);
        end

        if (ctl.emit_pop && !st.emit_last)
            emit_idx_next = emit_idx_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arq_mode_reg   <= RST_ARQ_MODE;
            rtx_tmo_reg    <= RST_RTX_TIMEOUT;
            total_reg      <= RST_TOTAL_PKTS;
            dup_thr_reg    <= RST_DUP_THRESH;
            base_reg       <= '0;
            head_seq_reg   <= '0;
            base_slot_reg  <= '0;
            next_slot_reg  <= '0;
            acked_reg      <= '1;
            last_ack_reg   <= '0;
            last_ack_v_reg <= 1'b0;
            dup_cnt_reg    <= '0;
            res_cnt_reg    <= '0;
            emit_idx_reg   <= '0;
        end
        else
        begin
            arq_mode_reg   <= arq_mode_next;
            rtx_tmo_reg    <= rtx_tmo_next;
            total_reg      <= total_next;
            dup_thr_reg    <= dup_thr_next;
            base_reg       <= base_next;
            head_seq_reg   <= head_seq_next;
            base_slot_reg  <= base_slot_next;
            next_slot_reg  <= next_slot_next;
            acked_reg      <= acked_next;
            last_ack_reg   <= last_ack_next;
            last_ack_v_reg <= last_ack_v_next;
            dup_cnt_reg    <= dup_cnt_next;
            res_cnt_reg    <= res_cnt_next;
            emit_idx_reg   <= emit_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sent_time_reg <= sent_time_next;
        ack_reg       <= ack_next;
        now_reg       <= now_next;
        walk_seq_reg  <= walk_seq_next;
        walk_slot_reg <= walk_slot_next;
        res_kind_reg  <= res_kind_next;
        res_seq_reg   <= res_seq_next;
        res_slot_reg  <= res_slot_next;
    end

    // result channel reads straight from the buffer; it holds while stalled
    always_comb
    begin
        if (res_cnt_reg == '0)
        begin
            out_kind    = KIND_STATUS;
            out_tx_seq  = '0;
            out_tx_slot = '0;
        end
        else
        begin
            out_kind    = res_kind_reg[emit_idx_reg];
            out_tx_seq  = res_seq_reg[emit_idx_reg];
            out_tx_slot = TX_SLOT_W'(res_slot_reg[emit_idx_reg]);
        end
    end

    assign out_base_now = base_reg;
    assign out_next_now = head_seq_reg;
    assign out_finished = (base_reg >= total_reg);
    assign out_last     = st.emit_last;

endmodule : swarq_datapath

`default_nettype wire

// ===== rtl/sliding_window_arq_sender_top.sv =====
// Top level of the sliding-window ARQ sender (selective repeat / go-back-N).
// Depends on swarq_pkg, swarq_in_if/swarq_out_if, swarq_ctrl, swarq_datapath.
//
//  channel   dir  handshake     transaction carries
//  --------  ---  ------------  ------------------------------------------------
//  in_ch     in   valid/ready   cmd, ack_number, now_time
//  out_ch    out  valid/ready   kind, tx_seq, tx_slot, base_now, next_now,
//                               finished, last
//  cfg       in   cfg_we only   cfg_index selects register, cfg_data holds value
//
// One command at a time. After acceptance: send issues one new packet per cycle
// (up to 5); timeout walks the outstanding slots one per cycle (at most WINDOW);
// ack checks the number, then moves the base one acked slot per cycle (at most
// WINDOW). Then one result per cycle while out_ch.ready is high.
// Reset is asynchronous; all slots read as acked and the window is empty.
// A stalled result holds its payload; in_ch.ready is low until the last
// result of the command has been taken.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_arq_sender_top
#(
    parameter int WINDOW = 4
)
(
    input  wire                                clk,
    input  wire                                rst_n,
    swarq_in_if.sink                           in_ch,
    swarq_out_if.source                        out_ch,
    input  wire                                cfg_we,
    input  wire  [swarq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [swarq_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import swarq_pkg::*;

    dp_ctl_t    ctl;
    dp_status_t st;

    // Controller: sequences capture, per-slot steps and result emission.
    swarq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_cmd    (in_ch.cmd),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .ctl       (ctl),
        .st        (st)
    );

    // Datapath: slot flags and send times, base/next, dup-ack tracking,
    // configuration and the per-command result buffer.
    swarq_datapath #(
        .WINDOW (WINDOW)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .st            (st),
        .in_ack_number (in_ch.ack_number),
        .in_now_time   (in_ch.now_time),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_kind      (out_ch.kind),
        .out_tx_seq    (out_ch.tx_seq),
        .out_tx_slot   (out_ch.tx_slot),
        .out_base_now  (out_ch.base_now),
        .out_next_now  (out_ch.next_now),
        .out_finished  (out_ch.finished),
        .out_last      (out_ch.last)
    );

endmodule : sliding_window_arq_sender_top

`default_nettype wire

// ===== rtl/swarq_checker.sv =====
// Port-level checks for the ARQ sender, bound to the top level.
// Depends on swarq_pkg for field widths and kind codes.
`timescale 1ns / 1ps
`default_nettype none

module swarq_checker
(
    input wire                               clk,
    input wire                               rst_n,
    input wire                               in_valid,
    input wire                               in_ready,
    input wire                               out_valid,
    input wire                               out_ready,
    input wire [swarq_pkg::KIND_W-1:0]       out_kind,
    input wire [swarq_pkg::SEQ_W-1:0]        out_tx_seq,
    input wire [swarq_pkg::SEQ_W-1:0]        out_next_now,
    input wire                               out_last
);
    import swarq_pkg::*;

    // one command at a time: no input taken while results are shown
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while results pending");

    // after the last result is taken the block is free again
    a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_last) |=> in_ready)
        else $error("not ready after last result");

    // a status-only result is always the only one
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_kind == KIND_STATUS)) |-> out_last)
        else $error("status result not last");

    // any transmission is of an already issued sequence number
    a_seq_issued: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_kind != KIND_STATUS)) |-> (out_tx_seq < out_next_now))
        else $error("transmitted sequence not below next");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_tx_seq)
                                       && $stable(out_kind)))
        else $error("stalled result changed");

endmodule : swarq_checker

bind sliding_window_arq_sender_top swarq_checker u_swarq_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_kind     (out_ch.kind),
    .out_tx_seq   (out_ch.tx_seq),
    .out_next_now (out_ch.next_now),
    .out_last     (out_ch.last)
);

`default_nettype wire
